// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(label, expr)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// ===== src/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// SDF ray marcher package
// Shared types and scene constants.
// ----------------------------------------------------------------------------
package sdf_pkg;
    localparam int FB = 16;
    localparam logic signed [47:0] ONE = 48'sd65536;
    localparam logic signed [47:0] HALF = 48'sd32768;
    localparam logic signed [47:0] QUARTER = 48'sd16384;
    localparam logic signed [47:0] STEP_CAP = 48'sd6554;
    localparam logic signed [47:0] TORUS_R1 = 48'sd121242;
    localparam logic signed [47:0] INV_SQRT3 = 48'sd619925132;

    typedef enum logic [5:0] {
        S_IDLE, S_PX, S_PY, S_PZ, S_SPH_SQ, S_SPH_SQRT, S_BOX_SQ, S_BOX_SQRT,
        S_TOR1_SQ, S_TOR1_SQRT, S_TOR2_SQ, S_TOR2_SQRT, S_OCT_SEL, S_OCT_MUL,
        S_OCT_SQ, S_OCT_SQRT, S_DECIDE, S_LEN_SQ, S_LEN_SQRT, S_DIST, S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [51:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [25:0] root;
    } sqrt_rsp_t;

    function automatic logic signed [47:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607) return 48'sd8388607;
        if (v < -48'sd8388608) return -48'sd8388608;
        return v;
    endfunction
endpackage

// ===== src/sdf_sqrt.sv =====
// ----------------------------------------------------------------------------
// SDF integer square root
// Bit-pair restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sdf_sqrt
    import sdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);
    logic [51:0] rem_reg, rem_next;
    logic [25:0] root_reg, root_next;
    logic [51:0] n_reg, n_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [53:0] trial;
    logic [53:0] acc;

    always_comb
    begin
        acc = {rem_reg, n_reg[51:50]};
        trial = acc - {26'd0, root_reg, 2'b01};
        rem_next = rem_reg;
        root_next = root_reg;
        n_next = n_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            root_next = '0;
            n_next = req.radicand;
            cnt_next = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[53])
            begin
                rem_next = trial[51:0];
                root_next = {root_reg[24:0], 1'b1};
            end
            else
            begin
                rem_next = acc[51:0];
                root_next = {root_reg[24:0], 1'b0};
            end
            n_next = {n_reg[49:0], 2'b00};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd25)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        n_reg <= n_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    `ASSERT_IMPL(a_done_after_busy, done_reg |-> $past(busy_reg))
    `ASSERT_NEVER(a_done_not_busy, done_reg && busy_reg)
    `ASSERT_IMPL(a_cnt_range, busy_reg |-> cnt_reg <= 5'd25)
endmodule

// ===== src/sdf_ray_marcher_top.sv =====
// ----------------------------------------------------------------------------
// SDF ray marcher top level
// Sphere traces one ray per request through a fixed four-shape scene.
// ----------------------------------------------------------------------------
// One ray direction request is taken when idle; the block then marches up to
// MAX_STEPS steps. Each step runs a short sequencer over one shared multiplier
// and one bit-serial square root (four or five roots a step); a hit then takes
// one more root for the direction length and one multiply for the distance.
// The result waits in an output register; the next request is accepted only
// once that register is empty or is being read in the same cycle.
// tdata in: dir_x[17:0], dir_y[35:18], dir_z[53:36]; out: hit[0],
// hit_distance[23:1]. Registers at 0x00..0x10: eye_x, eye_y, eye_z,
// far_depth, hit_threshold.
`include "assert_macros.svh"
module sdf_ray_marcher_top
    import sdf_pkg::*;
#(
    parameter int MAX_STEPS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // dir_x, dir_y, dir_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hit, hit_distance
);
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam logic [4:0] A_EX = 5'd0, A_EY = 5'd4, A_EZ = 5'd8,
                           A_FAR = 5'd12, A_THR = 5'd16;

    logic signed [23:0] ex_reg, ey_reg, ez_reg;
    logic [22:0] far_reg;
    logic [15:0] thr_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_reg <= 24'sd0;
            ey_reg <= 24'sd327680;
            ez_reg <= 24'sd458752;
            far_reg <= 23'd1966080;
            thr_reg <= 16'd66;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                A_EX:  ex_reg <= pwdata[23:0];
                A_EY:  ey_reg <= pwdata[23:0];
                A_EZ:  ez_reg <= pwdata[23:0];
                A_FAR: far_reg <= pwdata[22:0];
                A_THR: thr_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            A_EX:  prdata = {{8{ex_reg[23]}}, ex_reg};
            A_EY:  prdata = {{8{ey_reg[23]}}, ey_reg};
            A_EZ:  prdata = {{8{ez_reg[23]}}, ez_reg};
            A_FAR: prdata = {9'd0, far_reg};
            A_THR: prdata = {16'd0, thr_reg};
            default: prdata = '0;
        endcase
    end

    state_t state_reg, state_next;
    logic signed [47:0] dx_reg, dy_reg, dz_reg, t_reg, d_reg;
    logic signed [47:0] px_reg, py_reg, pz_reg, tmp_reg;
    logic signed [47:0] oa_reg, ob_reg, oc_reg;
    logic [SW-1:0] step_reg;
    logic out_valid_reg;
    logic [23:0] out_reg;

    sqrt_req_t sq_req;
    sqrt_rsp_t sq_rsp;
    sdf_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

    // shared 32x32 multiplier; every operand pair stays within 32 bits signed
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    function automatic logic signed [47:0] asr16(input logic signed [63:0] v);
        return v[63:16];
    endfunction
    function automatic logic signed [47:0] sabs(input logic signed [47:0] v);
        return v[47] ? -v : v;
    endfunction
    function automatic logic signed [47:0] pos(input logic signed [47:0] v);
        return v[47] ? 48'sd0 : v;
    endfunction
    function automatic logic [51:0] sq(input logic signed [47:0] v);
        logic signed [47:0] a;
        logic [49:0] p;
        a = sabs(v);
        p = a[24:0] * a[24:0];
        return {2'b00, p};
    endfunction

    // scene point offsets
    logic signed [47:0] sx, sy, bx, by, bz, tx, ty, tz, ox, oy, oz;
    logic signed [47:0] qbx, qby, qbz, qmax, apx, apy, apz, om, okk, ok;
    assign sx = px_reg - 4 * ONE; assign sy = py_reg + 3 * ONE;
    assign by = py_reg + 2 * ONE;
    assign tx = px_reg - ONE; assign ty = py_reg + 3 * ONE; assign tz = pz_reg + 8 * ONE;
    assign ox = px_reg - 4 * ONE; assign oy = py_reg + ONE; assign oz = pz_reg + 3 * ONE;
    assign bx = px_reg; assign bz = pz_reg;
    assign qbx = sabs(bx) - HALF; assign qby = sabs(by) - HALF; assign qbz = sabs(bz) - HALF;
    assign qmax = (qbx > qby) ? ((qbx > qbz) ? qbx : qbz) : ((qby > qbz) ? qby : qbz);
    assign apx = sabs(ox); assign apy = sabs(oy); assign apz = sabs(oz);
    assign om = apx + apy + apz - QUARTER;
    assign okk = (oc_reg - ob_reg + QUARTER) >>> 1;
    assign ok = okk[47] ? 48'sd0 : ((okk > QUARTER) ? QUARTER : okk);

    logic signed [47:0] root_s, step_add, t_new;
    assign root_s = {22'd0, sq_rsp.root};
    assign step_add = (sabs(d_reg) < STEP_CAP) ? sabs(d_reg) : STEP_CAP;
    assign t_new = t_reg + step_add;

    logic hit_now;
    assign hit_now = d_reg < $signed({32'd0, thr_reg});

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid && s_tready) state_next = S_PX;
            S_PX:        state_next = S_PY;
            S_PY:        state_next = S_PZ;
            S_PZ:        state_next = S_SPH_SQ;
            S_SPH_SQ:    state_next = S_SPH_SQRT;
            S_SPH_SQRT:  if (sq_rsp.done) state_next = S_BOX_SQ;
            S_BOX_SQ:    state_next = S_BOX_SQRT;
            S_BOX_SQRT:  if (sq_rsp.done) state_next = S_TOR1_SQ;
            S_TOR1_SQ:   state_next = S_TOR1_SQRT;
            S_TOR1_SQRT: if (sq_rsp.done) state_next = S_TOR2_SQ;
            S_TOR2_SQ:   state_next = S_TOR2_SQRT;
            S_TOR2_SQRT: if (sq_rsp.done) state_next = S_OCT_SEL;
            S_OCT_SEL:
                if (3 * apx < om || 3 * apy < om || 3 * apz < om)
                    state_next = S_OCT_SQ;
                else
                    state_next = S_OCT_MUL;
            S_OCT_MUL:   state_next = S_DECIDE;
            S_OCT_SQ:    state_next = S_OCT_SQRT;
            S_OCT_SQRT:  if (sq_rsp.done) state_next = S_DECIDE;
            S_DECIDE:
                if (hit_now) state_next = S_LEN_SQ;
                else if (t_new > $signed({25'd0, far_reg}) ||
                         step_reg == SW'(MAX_STEPS - 1))
                    state_next = S_OUT;
                else state_next = S_PX;
            S_LEN_SQ:    state_next = S_LEN_SQRT;
            S_LEN_SQRT:  if (sq_rsp.done) state_next = S_DIST;
            S_DIST:      state_next = S_OUT;
            S_OUT:       if (!out_valid_reg) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a = dx_reg[31:0];
        mul_b = t_reg[31:0];
        sq_req.start = 1'b0;
        sq_req.radicand = '0;
        case (state_reg)
            S_PX: mul_a = dx_reg[31:0];
            S_PY: mul_a = dy_reg[31:0];
            S_PZ: mul_a = dz_reg[31:0];
            S_OCT_MUL: begin mul_a = om[31:0]; mul_b = INV_SQRT3[31:0]; end
            S_DIST: begin mul_a = t_reg[31:0]; mul_b = root_s[31:0]; end
            S_SPH_SQ, S_BOX_SQ, S_TOR1_SQ, S_TOR2_SQ, S_OCT_SQ, S_LEN_SQ:
                sq_req.start = 1'b1;
            default: ;
        endcase
        case (state_reg)
            S_SPH_SQ:  sq_req.radicand = sq(sx) + sq(sy) + sq(pz_reg);
            S_BOX_SQ:  sq_req.radicand = sq(pos(qbx)) + sq(pos(qby)) + sq(pos(qbz));
            S_TOR1_SQ: sq_req.radicand = sq(tx) + sq(tz);
            S_TOR2_SQ: sq_req.radicand = sq(tmp_reg) + sq(ty);
            S_OCT_SQ:  sq_req.radicand = sq(oa_reg) + sq(ob_reg - QUARTER + ok) +
                                         sq(oc_reg - ok);
            S_LEN_SQ:  sq_req.radicand = sq(dx_reg) + sq(dy_reg) + sq(dz_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            if (state_reg == S_OUT && !out_valid_reg) out_valid_reg <= 1'b1;
        end
    end

    // candidate field distance for the shape finishing this cycle
    logic signed [47:0] dcand;
    logic signed [47:0] dist_v;
    assign dist_v = asr16(mul_p);

    always_comb
    begin
        case (state_reg)
            S_BOX_SQRT:  dcand = sat24(root_s + (qmax[47] ? qmax : 48'sd0));
            S_SPH_SQRT, S_TOR2_SQRT: dcand = sat24(root_s - HALF);
            S_OCT_MUL:   dcand = sat24({{14{mul_p[63]}}, mul_p[63:30]});
            default:     dcand = sat24(root_s);
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dx_reg <= {{30{s_tdata[17]}}, s_tdata[17:0]};
                dy_reg <= {{30{s_tdata[35]}}, s_tdata[35:18]};
                dz_reg <= {{30{s_tdata[53]}}, s_tdata[53:36]};
                t_reg <= '0;
                step_reg <= '0;
                d_reg <= '0;
            end
            S_PX: px_reg <= {{24{ex_reg[23]}}, ex_reg} + asr16(mul_p);
            S_PY: py_reg <= {{24{ey_reg[23]}}, ey_reg} + asr16(mul_p);
            S_PZ: pz_reg <= {{24{ez_reg[23]}}, ez_reg} + asr16(mul_p);
            S_SPH_SQRT: if (sq_rsp.done) d_reg <= dcand;
            S_BOX_SQRT, S_TOR2_SQRT, S_OCT_SQRT:
                if (sq_rsp.done && dcand < d_reg) d_reg <= dcand;
            S_TOR1_SQRT: if (sq_rsp.done) tmp_reg <= root_s - TORUS_R1;
            S_OCT_SEL:
            begin
                if (3 * apx < om) begin oa_reg <= apx; ob_reg <= apy; oc_reg <= apz; end
                else if (3 * apy < om) begin oa_reg <= apy; ob_reg <= apz; oc_reg <= apx; end
                else begin oa_reg <= apz; ob_reg <= apx; oc_reg <= apy; end
            end
            S_OCT_MUL: if (dcand < d_reg) d_reg <= dcand;
            S_DECIDE:
            begin
                step_reg <= step_reg + SW'(1);
                if (!hit_now) t_reg <= t_new;
                if (!hit_now) out_reg <= '0;
            end
            S_DIST:
                out_reg <= {(dist_v > 48'sd8388607) ? 23'd8388607 :
                            (dist_v[47] ? 23'd0 : dist_v[22:0]), 1'b1};
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_ready_idle, s_tready |-> state_reg == S_IDLE)
    `ASSERT_IMPL(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid)
    `ASSERT_IMPL(a_miss_zero, (m_tvalid && !m_tdata[0]) |-> m_tdata[23:1] == 23'd0)
endmodule

// ===== tb/sv/sdf_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray marcher testbench package
// Register map shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
package sdf_tb_pkg;
    typedef enum int {
        REG_EYE_X     = 0,
        REG_EYE_Y     = 1,
        REG_EYE_Z     = 2,
        REG_FAR_DEPTH = 3,
        REG_HIT_THR   = 4
    } reg_idx_t;

    // hit in bit 0, hit_distance above it
    typedef struct packed {
        logic [22:0] hit_distance;
        logic        hit;
    } ray_result_t;
endpackage

// ===== tb/sv/sdf_ray_marcher_checker.sv =====
// ----------------------------------------------------------------------------
// Ray marcher checker
// Mirrors the registers from the config port, traces every accepted ray
// request through the scene and compares each result in order.
// ----------------------------------------------------------------------------
module sdf_ray_marcher_checker
    import sdf_pkg::*;
    import sdf_tb_pkg::*;
#(
    parameter int MAX_STEPS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    longint eye_x, eye_y, eye_z, far_depth, hit_thr;
    ray_result_t ray_results_q[$];

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint length3(longint a, longint b, longint c);
        longint unsigned ua, ub, uc;
        ua = mag(a);
        ub = mag(b);
        uc = mag(c);
        return longint'(root_floor(ua * ua + ub * ub + uc * uc));
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint box_dist(longint x, longint y, longint z);
        longint qx, qy, qz;
        qx = mag(x) - longint'(HALF);
        qy = mag(y) - longint'(HALF);
        qz = mag(z) - longint'(HALF);
        return length3(lmax(qx, 0), lmax(qy, 0), lmax(qz, 0))
               + lmin(lmax(qx, lmax(qy, qz)), 0);
    endfunction

    function automatic longint torus_dist(longint x, longint y, longint z);
        longint ring;
        ring = length3(x, z, 0) - longint'(TORUS_R1);
        return length3(ring, y, 0) - longint'(HALF);
    endfunction

    function automatic longint octa_dist(longint x, longint y, longint z);
        longint px, py, pz, m, a, b, c, k, q;
        q = longint'(QUARTER);
        px = mag(x);
        py = mag(y);
        pz = mag(z);
        m = px + py + pz - q;
        if (3 * px < m)
        begin
            a = px; b = py; c = pz;
        end
        else if (3 * py < m)
        begin
            a = py; b = pz; c = px;
        end
        else if (3 * pz < m)
        begin
            a = pz; b = px; c = py;
        end
        else
            return (m * longint'(INV_SQRT3)) >>> 30;
        k = (c - b + q) >>> 1;
        if (k < 0)
            k = 0;
        if (k > q)
            k = q;
        return length3(a, b - q + k, c - k);
    endfunction

    function automatic longint scene_dist(longint x, longint y, longint z);
        longint one, d;
        one = longint'(ONE);
        d = clamp24(length3(x - 4 * one, y + 3 * one, z) - longint'(HALF));
        d = lmin(d, clamp24(box_dist(x, y + 2 * one, z)));
        d = lmin(d, clamp24(torus_dist(x - one, y + 3 * one, z + 8 * one)));
        d = lmin(d, clamp24(octa_dist(x - 4 * one, y + one, z + 3 * one)));
        return d;
    endfunction

    // Sphere trace one ray from the mirrored eye point.
    function automatic ray_result_t trace_ray(logic [55:0] req);
        longint dx, dy, dz, t, d, reach;
        ray_result_t res;
        dx = longint'($signed(req[17:0]));
        dy = longint'($signed(req[35:18]));
        dz = longint'($signed(req[53:36]));
        t = 0;
        d = 0;
        for (int i = 0; i < MAX_STEPS; i++)
        begin
            d = scene_dist(eye_x + ((dx * t) >>> 16), eye_y + ((dy * t) >>> 16),
                           eye_z + ((dz * t) >>> 16));
            if (d < hit_thr)
                break;
            t += lmin(mag(d), longint'(STEP_CAP));
            if (t > far_depth)
                break;
        end
        res = '0;
        if (d < hit_thr)
        begin
            reach = (t * length3(dx, dy, dz)) >>> 16;
            if (reach > 8388607)
                reach = 8388607;
            if (reach < 0)
                reach = 0;
            res.hit = 1'b1;
            res.hit_distance = reach[22:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ray_result_t got, want;
        if (!rst_n)
        begin
            eye_x = 0;
            eye_y = 5 * 65536;
            eye_z = 7 * 65536;
            far_depth = 30 * 65536;
            hit_thr = 66;
            ray_results_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (int'(paddr >> 2))
                    REG_EYE_X:     eye_x = longint'($signed(pwdata[23:0]));
                    REG_EYE_Y:     eye_y = longint'($signed(pwdata[23:0]));
                    REG_EYE_Z:     eye_z = longint'($signed(pwdata[23:0]));
                    REG_FAR_DEPTH: far_depth = longint'(pwdata[22:0]);
                    REG_HIT_THR:   hit_thr = longint'(pwdata[15:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (ray_results_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result hit=%0d dist=%0d",
                                 got.hit, got.hit_distance);
                end
                else
                begin
                    want = ray_results_q.pop_front();
                    if (got.hit !== want.hit || got.hit_distance !== want.hit_distance)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
                                     want.hit, want.hit_distance, got.hit, got.hit_distance);
                    end
                end
            end
            if (s_tvalid && s_tready)
                ray_results_q.push_back(trace_ray(s_tdata));
            pending = ray_results_q.size();
        end
    end
endmodule

// ===== tb/sv/sdf_ray_marcher_top_tb.sv =====
// ----------------------------------------------------------------------------
// Ray marcher testbench top
// Drives ray requests and register writes, shapes the handshakes and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module sdf_ray_marcher_top_tb
    import sdf_tb_pkg::*;
();
    localparam int ONE_Q = 65536;
    // Covers a ray of MAX_STEPS steps, plus the long hold-off.
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 3000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // dir_x[17:0], dir_y[35:18], dir_z[53:36]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // hit[0], hit_distance[23:1]

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    bit hold_taken;
    int hold_left;
    int quiet_cycles;

    sdf_ray_marcher_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sdf_ray_marcher_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: random stalls, plus one long hold-off so the block backs
    // up and stalls its request input.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic reg_write(reg_idx_t idx, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(int'(idx) * 4);
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_scene(int ex, int ey, int ez, int far, int thr);
        reg_write(REG_EYE_X, ex);
        reg_write(REG_EYE_Y, ey);
        reg_write(REG_EYE_Z, ez);
        reg_write(REG_FAR_DEPTH, far);
        reg_write(REG_HIT_THR, thr);
    endtask

    // One ray request; leaves tvalid high so back-to-back requests stay clean.
    task automatic send_ray(int dx, int dy, int dz);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, 18'(dz), 18'(dy), 18'(dx)};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int rand_comp();
        return $urandom_range(131072) - 65536;
    endfunction

    // Mostly rays aimed down at the box under the eye; the rest anywhere.
    task automatic send_random_ray();
        if ($urandom_range(9) < 8)
            send_ray($urandom_range(80000) - 40000, -$urandom_range(65536, 20000),
                     $urandom_range(80000) - 40000);
        else
            send_ray(rand_comp(), rand_comp(), rand_comp());
    endtask

    // Eye just above or inside the box top, short far depth: short marches.
    task automatic random_scene();
        int ey;
        int thr;
        if ($urandom_range(3) == 0)
            ey = -$urandom_range(150733, 111411);
        else
            ey = -$urandom_range(95027, 58982);
        thr = ($urandom_range(7) == 0) ? $urandom_range(65535, 1) : $urandom_range(2000, 1);
        set_scene($urandom_range(52428) - 26214, ey, $urandom_range(52428) - 26214,
                  $urandom_range(65536, 13107), thr);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b0;
        hold_taken = 1'b0;
        hold_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: axis and diagonal rays, extremes, zero and non-unit
        // directions from just above the box.
        set_scene(0, -78643, 0, 52429, 66);
        send_ray(0, -ONE_Q, 0);
        send_ray(0, ONE_Q, 0);
        send_ray(ONE_Q, 0, 0);
        send_ray(-ONE_Q, 0, 0);
        send_ray(0, 0, ONE_Q);
        send_ray(0, 0, -ONE_Q);
        send_ray(0, 0, 0);
        send_ray(ONE_Q, -ONE_Q, ONE_Q);
        send_ray(-ONE_Q, -ONE_Q, -ONE_Q);
        send_ray(37837, -37837, 37837);
        send_ray(21845, -43690, 65535);
        send_ray(-1, -65535, 1);
        drain();

        // Register extremes: far-away eye and zero far depth, then the eye
        // inside the box with the largest far depth.
        set_scene(-8388608, 8388607, -8388608, 0, 65535);
        send_ray(ONE_Q, ONE_Q, ONE_Q);
        send_ray(-ONE_Q, 0, 0);
        drain();
        set_scene(8388607, -8388608, 8388607, 0, 1);
        send_ray(0, -ONE_Q, 0);
        drain();
        set_scene(0, -2 * ONE_Q, 0, 8388607, 1);
        send_ray(0, -ONE_Q, 0);
        send_ray(ONE_Q, ONE_Q, -ONE_Q);
        drain();
        // Step limit: far from everything with the largest far depth.
        set_scene(8388607, 8388607, 8388607, 8388607, 1);
        send_ray(0, ONE_Q, 0);
        drain();
        // Largest threshold: hits at the first step from near the box.
        set_scene(0, -78643, 0, 52429, 65535);
        send_ray(0, -ONE_Q, 0);
        drain();

        // Random part in three idling modes, new registers between batches.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 9;  rx_idle_pct = 86; end
                1: begin tx_idle_pct = 86; rx_idle_pct = 9;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int batch = 0; batch < 4; batch++)
            begin
                drain();
                random_scene();
                if (phase == 0 && batch == 1)
                    hold_req = 1'b1;
                for (int n = 0; n < 23; n++)
                    send_random_ray();
            end
        end

        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
